/* src/iadz_pkg.sv */
// Shared types and constants of the input axis dead zone mapper.
// Depends on nothing; used by the controller, the datapath, the divider and the top level.
package iadz_pkg;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int VAL_W   = 24;
  localparam int TIME_W  = 63;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Divider: quotient bits of the mapped fraction, operand width, step counter
  localparam int QUOT_W    = 15;
  localparam int DIV_W     = 17;
  localparam int DIV_STEPS = QUOT_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Input commands
  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_WHEEL_SET = 2'd1,
    CMD_WHEEL_INC = 2'd2,
    CMD_FLUSH     = 2'd3
  } command_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DIRTY = 2'd0,
    KIND_AXIS  = 2'd1,
    KIND_WHEEL = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_AXIS_MIN   = 3'd0,
    REG_AXIS_MAX   = 3'd1,
    REG_FLAT_WIDTH = 3'd2,
    REG_ABS_MODE   = 3'd3,
    REG_WHEEL_AXIS = 3'd4,
    REG_WHEEL_HORZ = 3'd5
  } cfg_idx_e;

  // Strobes from the controller to the datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic classify;
    logic apply;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_sample;
    logic div_done;
    logic out_busy;
  } ctrl_stat_t;

endpackage

/* src/iadz_div.sv */
// Restoring divider that yields the fractional quotient (a << 15) / d, one bit a cycle.
// Depends on iadz_pkg; the dividend must be below the divisor.
module iadz_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [iadz_pkg::DIV_W-1:0] dividend_i,
  input  logic [iadz_pkg::DIV_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [iadz_pkg::QUOT_W-1:0] quot_o
);
  import iadz_pkg::*;

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvs_q;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;

  // Shift the remainder and subtract the divisor when it fits
  always_comb begin
    shifted = {rem_q, 1'b0};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    quot_d  = {quot_q[QUOT_W-2:0], ge};
    cnt_d   = cnt_q - CNT_W'(1);
  end

  // Hold the step counter; advance one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = (cnt_q == '0) && !start_i;
  assign quot_o = quot_q;

endmodule

/* src/iadz_ctrl.sv */
// Controller state machine of the dead zone mapper: sequences capture, mapping, divide,
// state update and result hand-off. Depends on iadz_pkg.
module iadz_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  iadz_pkg::ctrl_stat_t  stat_i,
  output iadz_pkg::ctrl_cmd_t   cmd_o
);
  import iadz_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_CLASS = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and strobes
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.is_sample ? ST_CLASS : ST_APPLY;
      end
      ST_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted transaction always starts with the mapping preparation
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_PREP)
    else $error("accepted transaction did not enter prep");

  // A finished divide moves on to the state update
  a_div_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && stat_i.div_done |=> state_q == ST_APPLY)
    else $error("divide done but no apply");

  // Hold the result step while the output register is still occupied
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && stat_i.out_busy |=> state_q == ST_EMIT && !cmd_o.load)
    else $error("emit left while output busy");

endmodule

/* src/iadz_dp.sv */
// Datapath of the dead zone mapper: configuration, captured transaction, dead zone bounds,
// divider, axis and wheel state and the output register. Depends on iadz_pkg and iadz_div.
module iadz_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iadz_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [iadz_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]                    command_i,
  input  logic signed [iadz_pkg::RAW_W-1:0] raw_sample_i,
  input  logic signed [iadz_pkg::RAW_W-1:0] wheel_amount_i,
  input  logic [15:0]                   modifier_keys_i,
  input  logic [iadz_pkg::TIME_W-1:0]   event_time_i,
  input  iadz_pkg::ctrl_cmd_t           cmd_i,
  output iadz_pkg::ctrl_stat_t          stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    result_kind_o,
  output logic signed [iadz_pkg::VAL_W-1:0] axis_value_o,
  output logic signed [iadz_pkg::RAW_W-1:0] wheel_x_o,
  output logic signed [iadz_pkg::RAW_W-1:0] wheel_y_o,
  output logic [15:0]                   report_modifiers_o,
  output logic [iadz_pkg::TIME_W-1:0]   report_time_o
);
  import iadz_pkg::*;

  typedef enum logic [2:0] {
    CLS_ZERO     = 3'd0,
    CLS_NEG_FULL = 3'd1,
    CLS_POS_FULL = 3'd2,
    CLS_DIV_LO   = 3'd3,
    CLS_DIV_HI   = 3'd4
  } class_e;

  // Configuration registers
  logic signed [RAW_W-1:0] min_q, max_q;
  logic [RAW_W-1:0]        flat_q;
  logic                    abs_q, wheel_q, horz_q;

  // Captured transaction
  command_e                cmd_q;
  logic signed [RAW_W-1:0] sample_q, amount_q;
  logic [15:0]             mods_in_q;
  logic [TIME_W-1:0]       time_in_q;

  // Mapping
  logic signed [17:0]      lo_q, hi_q, lo_d, hi_d;
  class_e                  class_q, class_d;
  logic [DIV_W-1:0]        div_a, div_b;
  logic                    div_done;
  logic [QUOT_W-1:0]       quot;

  // Axis and wheel state
  logic signed [VAL_W-1:0] pending_q, reported_q;
  logic signed [RAW_W-1:0] wheel_total_q;
  logic [15:0]             last_mods_q;
  logic [TIME_W-1:0]       last_time_q;

  // Flush result decided at apply
  logic                    res_hit_q;
  kind_e                   res_kind_q;
  logic signed [VAL_W-1:0] res_val_q;
  logic signed [RAW_W-1:0] res_wx_q, res_wy_q;

  // Output register
  logic                    out_valid_q;
  logic [1:0]              out_kind_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic signed [RAW_W-1:0] out_wx_q, out_wy_q;
  logic [15:0]             out_mods_q;
  logic [TIME_W-1:0]       out_time_q;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= -16'sd100;
      max_q   <= 16'sd100;
      flat_q  <= '0;
      abs_q   <= 1'b1;
      wheel_q <= 1'b0;
      horz_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_AXIS_MIN:   min_q   <= cfg_data_i;
        REG_AXIS_MAX:   max_q   <= cfg_data_i;
        REG_FLAT_WIDTH: flat_q  <= cfg_data_i;
        REG_ABS_MODE:   abs_q   <= cfg_data_i[0];
        REG_WHEEL_AXIS: wheel_q <= cfg_data_i[0];
        REG_WHEEL_HORZ: horz_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_SAMPLE;
    end else if (cmd_i.load) begin
      cmd_q <= command_e'(command_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q  <= raw_sample_i;
      amount_q  <= wheel_amount_i;
      mods_in_q <= modifier_keys_i;
      time_in_q <= event_time_i;
    end
  end

  // Dead zone bounds: center truncated toward zero, clipped to the span
  logic signed [16:0] span_sum, sum_adj;
  logic signed [17:0] center, mn18, mx18, flat18, lo_raw, hi_raw;

  always_comb begin
    span_sum = {min_q[RAW_W-1], min_q} + {max_q[RAW_W-1], max_q};
    sum_adj  = span_sum + {16'd0, span_sum[16]};
    center   = {{2{sum_adj[16]}}, sum_adj[16:1]};
    mn18     = {{2{min_q[RAW_W-1]}}, min_q};
    mx18     = {{2{max_q[RAW_W-1]}}, max_q};
    flat18   = {2'b00, flat_q};
    lo_raw   = center - flat18;
    hi_raw   = center + flat18;
    lo_d     = (lo_raw < mn18) ? mn18 : lo_raw;
    hi_d     = (hi_raw > mx18) ? mx18 : hi_raw;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Classify the sample and set up the divide operands
  logic signed [17:0] s18, num_diff, den_diff;

  always_comb begin
    s18      = {{2{sample_q[RAW_W-1]}}, sample_q};
    class_d  = CLS_ZERO;
    num_diff = '0;
    den_diff = '0;
    if (s18 < lo_q) begin
      num_diff = s18 - mn18;
      den_diff = lo_q - mn18;
      class_d  = (s18 <= mn18) ? CLS_NEG_FULL : CLS_DIV_LO;
    end else if (s18 > hi_q) begin
      num_diff = s18 - hi_q;
      den_diff = mx18 - hi_q;
      class_d  = (s18 >= mx18) ? CLS_POS_FULL : CLS_DIV_HI;
    end
    div_a = num_diff[DIV_W-1:0];
    div_b = den_diff[DIV_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      class_q <= class_d;
    end
  end

  iadz_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.classify),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Mapped value and saturating sums
  logic signed [16:0]      map_v;
  logic signed [VAL_W:0]   acc_sum;
  logic signed [VAL_W-1:0] acc_sat, sample_val;
  logic signed [RAW_W:0]   wheel_sum;
  logic signed [RAW_W-1:0] wheel_sat;

  always_comb begin
    case (class_q)
      CLS_NEG_FULL: map_v = -17'sd32768;
      CLS_POS_FULL: map_v = 17'sd32768;
      CLS_DIV_LO:   map_v = $signed({2'b00, quot}) - 17'sd32768;
      CLS_DIV_HI:   map_v = $signed({2'b00, quot});
      default:      map_v = '0;
    endcase
    acc_sum = {pending_q[VAL_W-1], pending_q} + {{8{map_v[16]}}, map_v};
    if (acc_sum > 25'sd8388607) begin
      acc_sat = 24'sh7FFFFF;
    end else if (acc_sum < -25'sd8388608) begin
      acc_sat = 24'sh800000;
    end else begin
      acc_sat = acc_sum[VAL_W-1:0];
    end
    sample_val = abs_q ? {{7{map_v[16]}}, map_v} : acc_sat;

    if (cmd_q == CMD_WHEEL_SET) begin
      wheel_sum = {amount_q[RAW_W-1], amount_q};
    end else begin
      wheel_sum = {wheel_total_q[RAW_W-1], wheel_total_q} + {amount_q[RAW_W-1], amount_q};
    end
    if (wheel_sum > 17'sd32767) begin
      wheel_sat = 16'sh7FFF;
    end else if (wheel_sum < -17'sd32768) begin
      wheel_sat = 16'sh8000;
    end else begin
      wheel_sat = wheel_sum[RAW_W-1:0];
    end
  end

  // Result decision at the emit step
  logic emit_hit;
  assign emit_hit = (cmd_q == CMD_SAMPLE) ? (pending_q != reported_q) : res_hit_q;

  // Update axis and wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      reported_q    <= '0;
      wheel_total_q <= '0;
      last_mods_q   <= '0;
      last_time_q   <= '0;
      res_hit_q     <= 1'b0;
    end else if (cmd_i.apply) begin
      case (cmd_q)
        CMD_SAMPLE: begin
          pending_q <= sample_val;
          res_hit_q <= 1'b0;
        end
        CMD_WHEEL_SET, CMD_WHEEL_INC: begin
          wheel_total_q <= wheel_sat;
          last_mods_q   <= mods_in_q;
          last_time_q   <= time_in_q;
          res_hit_q     <= 1'b0;
        end
        CMD_FLUSH: begin
          if (abs_q) begin
            res_hit_q <= (pending_q != reported_q);
            if (pending_q != reported_q) begin
              reported_q <= pending_q;
            end
          end else if (wheel_q) begin
            res_hit_q <= (wheel_total_q != '0);
            if (wheel_total_q != '0) begin
              wheel_total_q <= '0;
            end
          end else begin
            res_hit_q <= (pending_q != '0);
            if (pending_q != '0) begin
              reported_q <= pending_q;
              pending_q  <= '0;
            end
          end
        end
        default: begin
          res_hit_q <= 1'b0;
        end
      endcase
    end else if (cmd_i.emit && emit_hit && cmd_q == CMD_SAMPLE) begin
      last_time_q <= time_in_q;
    end
  end

  // Flush result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      if (!abs_q && wheel_q) begin
        res_kind_q <= KIND_WHEEL;
        res_val_q  <= '0;
        res_wx_q   <= horz_q ? wheel_total_q : '0;
        res_wy_q   <= horz_q ? '0 : wheel_total_q;
      end else begin
        res_kind_q <= KIND_AXIS;
        res_val_q  <= pending_q;
        res_wx_q   <= '0;
        res_wy_q   <= '0;
      end
    end
  end

  // Output register: load on a hit, drop once the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && emit_hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && emit_hit) begin
      out_mods_q <= last_mods_q;
      if (cmd_q == CMD_SAMPLE) begin
        out_kind_q <= KIND_DIRTY;
        out_val_q  <= pending_q;
        out_wx_q   <= '0;
        out_wy_q   <= '0;
        out_time_q <= time_in_q;
      end else begin
        out_kind_q <= res_kind_q;
        out_val_q  <= res_val_q;
        out_wx_q   <= res_wx_q;
        out_wy_q   <= res_wy_q;
        out_time_q <= last_time_q;
      end
    end
  end

  assign stat_o.is_sample = (cmd_q == CMD_SAMPLE);
  assign stat_o.div_done  = div_done;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign axis_value_o       = out_val_q;
  assign wheel_x_o          = out_wx_q;
  assign wheel_y_o          = out_wy_q;
  assign report_modifiers_o = out_mods_q;
  assign report_time_o      = out_time_q;

endmodule

/* src/input_axis_dead_zone_mapper.sv */
// Input axis dead zone mapper: usage.
// Input channel (in_valid_i/in_ready_o) takes one transaction: a command (raw sample,
// wheel set, wheel increment or flush tick) with its sample, wheel amount, modifier
// bits and timestamp. The output channel (out_valid_o/out_ready_i) delivers at most one
// result per transaction: a dirty notice, a changed axis value or a wheel report.
// The configuration port writes register cfg_index_i from cfg_data_i when cfg_we_i is
// high; write it only while the block is idle. Indexes beyond the list are ignored.
// One transaction is worked on at a time. A raw sample passes through the prep and
// classify steps, the 15-step restoring divider that forms the mapped fraction, and
// the apply and emit steps. Wheel and flush commands skip the classify and divide steps.
// A result appears in the output register in the cycle after the emit step.
// The output register parts the two channels: while a result waits, the next
// transaction is accepted and worked on; it only waits at its own emit step if the
// receiver still holds the previous result.
// Reset (rst_ni low, asynchronous) restores the register defaults (span -100..100,
// no dead zone, absolute mode) and clears pending, reported and wheel state.
// Depends on iadz_pkg, iadz_ctrl, iadz_dp and iadz_div.
module input_axis_dead_zone_mapper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [iadz_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [iadz_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic signed [iadz_pkg::RAW_W-1:0] raw_sample_i,
  input  logic signed [iadz_pkg::RAW_W-1:0] wheel_amount_i,
  input  logic [15:0]                       modifier_keys_i,
  input  logic [iadz_pkg::TIME_W-1:0]       event_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        result_kind_o,
  output logic signed [iadz_pkg::VAL_W-1:0] axis_value_o,
  output logic signed [iadz_pkg::RAW_W-1:0] wheel_x_o,
  output logic signed [iadz_pkg::RAW_W-1:0] wheel_y_o,
  output logic [15:0]                       report_modifiers_o,
  output logic [iadz_pkg::TIME_W-1:0]       report_time_o
);
  import iadz_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequence each transaction
  iadz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Map, accumulate and report
  iadz_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .command_i          (command_i),
    .raw_sample_i       (raw_sample_i),
    .wheel_amount_i     (wheel_amount_i),
    .modifier_keys_i    (modifier_keys_i),
    .event_time_i       (event_time_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .axis_value_o       (axis_value_o),
    .wheel_x_o          (wheel_x_o),
    .wheel_y_o          (wheel_y_o),
    .report_modifiers_o (report_modifiers_o),
    .report_time_o      (report_time_o)
  );

endmodule

/* dv/input_axis_dead_zone_mapper_tb.sv */
// Self-checking testbench for input_axis_dead_zone_mapper: predicts every result in a scoreboard
// and drives the valid/ready channels and the register port with directed and random traffic.
// Depends on iadz_pkg and the mapper RTL.
module input_axis_dead_zone_mapper_tb;
  import iadz_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int SETTLE      = 30;    // covers the sample path through the divider
  localparam int MAX_LINES   = 40;

  // Indexes past the register list, written to check that they are ignored
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // One result as seen on the output channel
  typedef struct {
    logic [1:0]        kind;
    logic [VAL_W-1:0]  value;
    logic [RAW_W-1:0]  wheel_x;
    logic [RAW_W-1:0]  wheel_y;
    logic [15:0]       mods;
    logic [TIME_W-1:0] stamp;
  } axis_report_t;

  // Scoreboard: mirrors registers and state, queues the reports the mapper owes
  class axis_report_board;
    localparam int Q_ONE   = 32768;
    localparam int Q24_MAX = 8388607;
    localparam int Q24_MIN = -8388608;

    int axis_min, axis_max, flat;
    bit abs_mode, wheel_mode, wheel_horz;

    logic signed [VAL_W-1:0] pending, reported;
    logic signed [RAW_W-1:0] wheel_sum;
    logic [15:0]             mods;
    logic [TIME_W-1:0]       stamp;

    axis_report_t due_reports[$];
    int errors;

    function new();
      axis_min   = -100;
      axis_max   = 100;
      flat       = 0;
      abs_mode   = 1'b1;
      wheel_mode = 1'b0;
      wheel_horz = 1'b0;
      pending    = '0;
      reported   = '0;
      wheel_sum  = '0;
      mods       = '0;
      stamp      = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_AXIS_MIN:   axis_min = int'($signed(data));
        REG_AXIS_MAX:   axis_max = int'($signed(data));
        REG_FLAT_WIDTH: flat = int'(data);
        REG_ABS_MODE:   abs_mode = data[0];
        REG_WHEEL_AXIS: wheel_mode = data[0];
        REG_WHEEL_HORZ: wheel_horz = data[0];
        default: ;
      endcase
    endfunction

    // Dead zone edges, clipped to the span
    function void zone_edges(output int lo, output int hi);
      int center;
      center = (axis_min + axis_max) / 2;
      lo = center - flat;
      hi = center + flat;
      if (lo < axis_min) lo = axis_min;
      if (hi > axis_max) hi = axis_max;
    endfunction

    // Map a raw reading to Q2.15 (-1.0 to +1.0), flooring the linear parts
    function int scale_sample(int raw_val);
      int lo, hi;
      longint num;
      zone_edges(lo, hi);
      if (raw_val < lo) begin
        if (raw_val <= axis_min) return -Q_ONE;
        num = longint'(raw_val - axis_min) * Q_ONE / longint'(lo - axis_min);
        return int'(num) - Q_ONE;
      end
      if (raw_val > hi) begin
        if (raw_val >= axis_max) return Q_ONE;
        num = longint'(raw_val - hi) * Q_ONE / longint'(axis_max - hi);
        return int'(num);
      end
      return 0;
    endfunction

    function void queue_report(kind_e kind, logic [VAL_W-1:0] value,
                               logic [RAW_W-1:0] wx, logic [RAW_W-1:0] wy);
      axis_report_t r;
      r.kind    = kind;
      r.value   = value;
      r.wheel_x = wx;
      r.wheel_y = wy;
      r.mods    = mods;
      r.stamp   = stamp;
      due_reports.push_back(r);
    endfunction

    // Advance the mirrored state by one accepted transaction
    function void note_transaction(command_e cmd, logic [RAW_W-1:0] raw_val,
                                   logic [RAW_W-1:0] amount, logic [15:0] key_bits,
                                   logic [TIME_W-1:0] event_stamp);
      int v, sum, w;
      case (cmd)
        CMD_SAMPLE: begin
          v = scale_sample(int'($signed(raw_val)));
          if (abs_mode) begin
            pending = v[VAL_W-1:0];
          end else begin
            sum = int'(pending) + v;
            if (sum > Q24_MAX) sum = Q24_MAX;
            if (sum < Q24_MIN) sum = Q24_MIN;
            pending = sum[VAL_W-1:0];
          end
          if (pending != reported) begin
            stamp = event_stamp;
            queue_report(KIND_DIRTY, pending, '0, '0);
          end
        end
        CMD_WHEEL_SET, CMD_WHEEL_INC: begin
          w = int'($signed(amount));
          if (cmd == CMD_WHEEL_INC) w += int'(wheel_sum);
          if (w > 32767) w = 32767;
          if (w < -32768) w = -32768;
          wheel_sum = w[RAW_W-1:0];
          mods      = key_bits;
          stamp     = event_stamp;
        end
        default: begin
          if (abs_mode) begin
            if (pending != reported) begin
              reported = pending;
              queue_report(KIND_AXIS, reported, '0, '0);
            end
          end else if (wheel_mode) begin
            if (wheel_sum != 0) begin
              if (wheel_horz) queue_report(KIND_WHEEL, '0, wheel_sum, '0);
              else queue_report(KIND_WHEEL, '0, '0, wheel_sum);
              wheel_sum = '0;
            end
          end else if (pending != 0) begin
            reported = pending;
            pending  = '0;
            queue_report(KIND_AXIS, reported, '0, '0);
          end
        end
      endcase
    endfunction

    function void report_mismatch(string what);
      errors++;
      if (errors <= MAX_LINES) $display("%0t mismatch: %s", $time, what);
    endfunction

    // Compare a delivered result against the oldest queued report
    function void check_result(axis_report_t got);
      axis_report_t want;
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with no report due", got.kind));
        return;
      end
      want = due_reports.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report_mismatch($sformatf("axis value %0d, want %0d",
                                  $signed(got.value), $signed(want.value)));
      if (got.wheel_x !== want.wheel_x)
        report_mismatch($sformatf("wheel x %0d, want %0d",
                                  $signed(got.wheel_x), $signed(want.wheel_x)));
      if (got.wheel_y !== want.wheel_y)
        report_mismatch($sformatf("wheel y %0d, want %0d",
                                  $signed(got.wheel_y), $signed(want.wheel_y)));
      if (got.mods !== want.mods)
        report_mismatch($sformatf("modifiers %h, want %h", got.mods, want.mods));
      if (got.stamp !== want.stamp)
        report_mismatch($sformatf("timestamp %h, want %h", got.stamp, want.stamp));
    endfunction
  endclass

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [IDX_W-1:0]         cfg_index_i    = '0;
  logic [CFG_W-1:0]         cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               command_i      = '0;
  logic signed [RAW_W-1:0]  raw_sample_i   = '0;
  logic signed [RAW_W-1:0]  wheel_amount_i = '0;
  logic [15:0]              modifier_keys_i = '0;
  logic [TIME_W-1:0]        event_time_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [1:0]               result_kind_o;
  logic signed [VAL_W-1:0]  axis_value_o;
  logic signed [RAW_W-1:0]  wheel_x_o;
  logic signed [RAW_W-1:0]  wheel_y_o;
  logic [15:0]              report_modifiers_o;
  logic [TIME_W-1:0]        report_time_o;

  axis_report_board sb;
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int ready_hold   = 0;
  int quiet_cycles = 0;

  input_axis_dead_zone_mapper u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .raw_sample_i       (raw_sample_i),
    .wheel_amount_i     (wheel_amount_i),
    .modifier_keys_i    (modifier_keys_i),
    .event_time_i       (event_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .axis_value_o       (axis_value_o),
    .wheel_x_o          (wheel_x_o),
    .wheel_y_o          (wheel_y_o),
    .report_modifiers_o (report_modifiers_o),
    .report_time_o      (report_time_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the receiver in random bursts counted down by ready_hold
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= ready_hold - 1;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check delivered results, then note accepted transactions
  always @(posedge clk_i) begin
    axis_report_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.kind    = result_kind_o;
        got.value   = axis_value_o;
        got.wheel_x = wheel_x_o;
        got.wheel_y = wheel_y_o;
        got.mods    = report_modifiers_o;
        got.stamp   = report_time_o;
        sb.check_result(got);
      end
      if (in_valid_i && in_ready_o)
        sb.note_transaction(command_e'(command_i), raw_sample_i, wheel_amount_i,
                            modifier_keys_i, event_time_i);
    end
  end

  // Give up when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("input_axis_dead_zone_mapper_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rnd_stamp();
    return {31'($urandom), $urandom};
  endfunction

  // Pick a reading near the interesting points of the current span
  function automatic logic [RAW_W-1:0] pick_sample();
    int lo, hi, low, high, v;
    sb.zone_edges(lo, hi);
    low  = (sb.axis_min < sb.axis_max) ? sb.axis_min : sb.axis_max;
    high = (sb.axis_min < sb.axis_max) ? sb.axis_max : sb.axis_min;
    case ($urandom_range(0, 9))
      0: v = sb.axis_min;
      1: v = sb.axis_max;
      2: v = lo + int'($urandom_range(0, 2)) - 1;
      3: v = hi + int'($urandom_range(0, 2)) - 1;
      4, 5: v = low + int'($urandom_range(0, high - low));
      default: v = int'($signed(16'($urandom)));
    endcase
    return v[RAW_W-1:0];
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send(command_e cmd, logic [RAW_W-1:0] raw_val, logic [RAW_W-1:0] amount,
                      logic [15:0] key_bits, logic [TIME_W-1:0] event_stamp);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    raw_sample_i    <= raw_val;
    wheel_amount_i  <= amount;
    modifier_keys_i <= key_bits;
    event_time_i    <= event_stamp;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold the sender until every report is in and the last transaction has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Rewrite every register once the mapper is idle; flags carry junk upper bits
  task automatic configure(int mn, int mx, int fl, bit abs_on, bit wheel_on, bit horz_on);
    wait_idle();
    write_reg(REG_AXIS_MIN, 16'(mn));
    write_reg(REG_AXIS_MAX, 16'(mx));
    write_reg(REG_FLAT_WIDTH, 16'(fl));
    write_reg(REG_ABS_MODE, {15'($urandom), abs_on});
    write_reg(REG_WHEEL_AXIS, {15'($urandom), wheel_on});
    write_reg(REG_WHEEL_HORZ, {15'($urandom), horz_on});
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // One random phase; a nonzero push drives a relative axis into saturation
  task automatic run_phase(int n_items, int push);
    int mn, mx, fl, r, sample_end, flush_end;
    bit abs_on, wheel_on, horz_on;
    command_e cmd;
    logic [RAW_W-1:0] raw_val, amount;
    abs_on   = $urandom_range(0, 1);
    wheel_on = $urandom_range(0, 1);
    horz_on  = $urandom_range(0, 1);
    if (push != 0) begin
      mn = -1000; mx = 1000; fl = 100;
      abs_on = 1'b0; wheel_on = 1'b0;
    end else begin
      case ($urandom_range(0, 5))
        0: begin mn = -32768; mx = 32767; fl = 0; end
        1: begin mn = -32768; mx = 32767; fl = $urandom_range(0, 65535); end
        2: begin mn = int'($signed(16'($urandom))); mx = mn; fl = $urandom_range(0, 50); end
        3: begin
          mn = $urandom_range(0, 30000);
          mx = mn - int'($urandom_range(1, 30000));
          fl = $urandom_range(0, 500);
        end
        default: begin
          mn = -int'($urandom_range(0, 3000));
          mx = $urandom_range(0, 3000);
          fl = $urandom_range(0, 400);
        end
      endcase
    end
    configure(mn, mx, fl, abs_on, wheel_on, horz_on);
    if (abs_on) begin
      sample_end = 50; flush_end = 75;
    end else if (wheel_on) begin
      sample_end = 25; flush_end = 50;
    end else begin
      sample_end = 60; flush_end = 80;
    end
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (push != 0) cmd = (i == n_items - 1) ? CMD_FLUSH : CMD_SAMPLE;
      else if (r < sample_end) cmd = CMD_SAMPLE;
      else if (r < flush_end) cmd = CMD_FLUSH;
      else if (r < flush_end + (100 - flush_end) / 2) cmd = CMD_WHEEL_SET;
      else cmd = CMD_WHEEL_INC;
      if (push != 0 && $urandom_range(0, 9) != 0) raw_val = (push > 0) ? 16'(mx) : 16'(mn);
      else raw_val = pick_sample();
      if ($urandom_range(0, 3) == 0) amount = 16'($urandom);
      else amount = 16'(int'($urandom_range(0, 10)) - 5);
      if ($urandom_range(0, 99) == 0) wait_idle();
      send(cmd, raw_val, amount, 16'($urandom), rnd_stamp());
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Absolute axis: both ends, the linear parts, the dead zone and its edges
    configure(-100, 100, 10, 1'b1, 1'b0, 1'b0);
    send(CMD_SAMPLE, 16'h8000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'h7fff, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(-50), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(5), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(11), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(100), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(99), 16'h0000, 16'h0000, rnd_stamp());

    // Wheel totals saturating both ways, with extreme modifiers and timestamps
    send(CMD_WHEEL_SET, 16'h0000, 16'h7fff, 16'hffff, {TIME_W{1'b1}});
    send(CMD_WHEEL_INC, 16'hffff, 16'h0001, 16'h0000, '0);
    send(CMD_WHEEL_SET, 16'h0000, 16'h8000, 16'h5555, rnd_stamp());
    send(CMD_WHEEL_INC, 16'h0000, 16'hffff, 16'haaaa, rnd_stamp());

    // Relative wheel on each component, with an empty flush between
    configure(-100, 100, 10, 1'b0, 1'b1, 1'b1);
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_WHEEL_INC, 16'h0000, 16'(300), 16'h0f0f, rnd_stamp());
    configure(-100, 100, 10, 1'b0, 1'b1, 1'b0);
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());

    // Relative axis: accumulate, flush, flush with nothing pending
    configure(-100, 100, 10, 1'b0, 1'b0, 1'b0);
    send(CMD_SAMPLE, 16'(100), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_FLUSH, 16'h0000, 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(0), 16'h0000, 16'h0000, rnd_stamp());

    // Zero-width span
    configure(7, 7, 0, 1'b1, 1'b0, 1'b0);
    send(CMD_SAMPLE, 16'(6), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(8), 16'h0000, 16'h0000, rnd_stamp());
    send(CMD_SAMPLE, 16'(7), 16'h0000, 16'h0000, rnd_stamp());

    // Random phases; two drive the relative sum into saturation, the last runs at full rate
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      gaps_on   = (p < 11) && ($urandom_range(0, 3) != 0);
      stalls_on = (p < 11) && ($urandom_range(0, 3) != 0);
      if (p == 2) run_phase(300, 1);
      else if (p == 6) run_phase(300, -1);
      else run_phase(135, 0);
    end

    wait_idle();
    if (sb.errors == 0 && sb.due_reports.size() == 0)
      $display("input_axis_dead_zone_mapper_tb: done, clean");
    else
      $display("input_axis_dead_zone_mapper_tb: done, errors");
    $finish;
  end

endmodule
